// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker module of the checksum block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define ADL_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that is also checked while reset is asserted.
`define ADL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/adl_pkg.sv -----
// Package with the constants, types and helper function of the Adler-32 checksum block.
`default_nettype none

package adl_pkg;

    localparam int unsigned LANES     = 4;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CNT_IN_W  = 3;
    localparam int unsigned SUM_W     = 16;
    localparam int unsigned SEED_W    = 32;
    localparam int unsigned CNT_W     = $clog2(LANES + 1);
    localparam int unsigned WBYTE_W   = BYTE_W + CNT_W;
    localparam int unsigned BSUM_W    = SUM_W + CNT_W + 1;
    localparam int unsigned HI_W      = BSUM_W - SUM_W;

    localparam int unsigned CNT_LSB   = LANES * BYTE_W;
    localparam int unsigned SEED_LSB  = CNT_LSB + CNT_IN_W;
    localparam int unsigned S_BITS    = SEED_LSB + SEED_W;
    localparam int unsigned S_TDATA_W = ((S_BITS + 7) / 8) * 8;
    localparam int unsigned M_TDATA_W = 2 * SUM_W;

    localparam logic [SUM_W:0] ADLER_MOD = 17'd65521;
    localparam logic [SUM_W:0] FOLD_MUL  = 17'd15;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             first;
        logic [SUM_W-1:0] seed_a;
        logic [SUM_W-1:0] seed_b;
        logic             last;
    } t_ctrl;

    // Reduces a value below twice the modulus into the range of the modulus.
    function automatic logic [SUM_W-1:0] fold17(input logic [SUM_W:0] v);
        logic [SUM_W:0] d;
        begin
            d = v - ADLER_MOD;
            fold17 = (v >= ADLER_MOD) ? d[SUM_W-1:0] : v[SUM_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

// ----- rtl/adl_lane.sv -----
// One byte lane: masks its byte and forms the byte weighted by its distance to the item end.
`default_nettype none

module adl_lane (
    input  wire logic                         i_clk,
    input  wire logic                         i_en,
    input  wire logic [adl_pkg::BYTE_W-1:0]   i_byte,
    input  wire logic [adl_pkg::CNT_W-1:0]    i_weight,
    output logic      [adl_pkg::BYTE_W-1:0]   o_byte,
    output logic      [adl_pkg::WBYTE_W-1:0]  o_wbyte
);
    import adl_pkg::*;

    logic [BYTE_W-1:0]  r_byte;
    logic [WBYTE_W-1:0] r_wbyte;
    logic [BYTE_W-1:0]  n_byte;
    logic [WBYTE_W-1:0] n_wbyte;

    always_comb begin
        n_byte  = (i_weight != '0) ? i_byte : '0;
        n_wbyte = WBYTE_W'(i_byte) * WBYTE_W'(i_weight);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_byte  <= n_byte;
            r_wbyte <= n_wbyte;
        end
    end

    assign o_byte  = r_byte;
    assign o_wbyte = r_wbyte;

endmodule

`default_nettype wire

// ----- rtl/adl_merge.sv -----
// Merging stage: adds the lane bytes and the weighted lane bytes of one item.
`default_nettype none

module adl_merge (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_en,
    input  wire logic [adl_pkg::LANES-1:0][adl_pkg::BYTE_W-1:0]  i_byte,
    input  wire logic [adl_pkg::LANES-1:0][adl_pkg::WBYTE_W-1:0] i_wbyte,
    input  wire adl_pkg::t_ctrl                            i_ctrl,
    output logic      [adl_pkg::SUM_W-1:0]                 o_sum_s,
    output logic      [adl_pkg::SUM_W-1:0]                 o_sum_w,
    output adl_pkg::t_ctrl                                 o_ctrl
);
    import adl_pkg::*;

    logic [SUM_W-1:0] r_sum_s;
    logic [SUM_W-1:0] r_sum_w;
    t_ctrl            r_ctrl;
    logic [SUM_W-1:0] n_sum_s;
    logic [SUM_W-1:0] n_sum_w;
    logic [SUM_W-1:0] raw_w;

    always_comb begin
        n_sum_s = '0;
        raw_w   = '0;
        for (int i = 0; i < LANES; i++) begin
            n_sum_s = n_sum_s + SUM_W'(i_byte[i]);
            raw_w   = raw_w + SUM_W'(i_wbyte[i]);
        end
        n_sum_w = fold17({1'b0, raw_w});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum_s <= n_sum_s;
            r_sum_w <= n_sum_w;
            r_ctrl  <= i_ctrl;
        end
    end

    assign o_sum_s = r_sum_s;
    assign o_sum_w = r_sum_w;
    assign o_ctrl  = r_ctrl;

endmodule

`default_nettype wire

// ----- rtl/adl_accum.sv -----
// Running sums A and B, updated once per item, and the registered checksum output.
`default_nettype none

module adl_accum (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_adv,
    input  wire logic [adl_pkg::SUM_W-1:0]           i_sum_s,
    input  wire logic [adl_pkg::SUM_W-1:0]           i_sum_w,
    input  wire adl_pkg::t_ctrl                      i_ctrl,
    input  wire logic                                i_out_ready,
    output logic                                     o_out_valid,
    output logic      [adl_pkg::M_TDATA_W-1:0]       o_out_data,
    output logic                                     o_out_free
);
    import adl_pkg::*;

    logic [SUM_W-1:0]     r_sum_a;
    logic [SUM_W-1:0]     r_sum_b;
    logic                 r_out_valid;
    logic [M_TDATA_W-1:0] r_out_data;
    logic [SUM_W-1:0]     n_sum_a;
    logic [SUM_W-1:0]     n_sum_b;
    logic [SUM_W-1:0]     a0;
    logic [SUM_W-1:0]     b0;
    logic [BSUM_W-1:0]    prod;
    logic [BSUM_W-1:0]    bsum;
    logic [HI_W-1:0]      hi;
    logic [SUM_W:0]       folded;

    always_comb begin
        a0      = i_ctrl.first ? i_ctrl.seed_a : r_sum_a;
        b0      = i_ctrl.first ? i_ctrl.seed_b : r_sum_b;
        n_sum_a = fold17({1'b0, a0} + {1'b0, i_sum_s});
        prod    = BSUM_W'(a0) * BSUM_W'(i_ctrl.count);
        bsum    = BSUM_W'(b0) + prod + BSUM_W'(i_sum_w);
        hi      = bsum[BSUM_W-1:SUM_W];
        folded  = {1'b0, bsum[SUM_W-1:0]} + (17'(hi) * FOLD_MUL);
        n_sum_b = fold17(folded);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_a     <= SUM_W'(1);
            r_sum_b     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_adv) begin
                r_sum_a <= n_sum_a;
                r_sum_b <= n_sum_b;
            end
            if (i_adv && i_ctrl.last) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && i_ctrl.last) begin
            r_out_data <= {n_sum_b, n_sum_a};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_free  = !r_out_valid || i_out_ready;

endmodule

`default_nettype wire

// ----- rtl/adler32_checksum.sv -----
// Adler-32 checksum engine: four byte lanes per transfer, lane merge, and running sums.
// A checksum is shown once the transfer that carries last has passed the lane, merge and output registers.
// Throughput: one input transfer per cycle unless the output stalls; the combinational A/B sum update sets this.
// A checksum held on the output stalls the next item that carries last and those behind it.
// Reset (i_rst_n low, synchronous) sets sum A to 1, sum B to 0 and empties the pipeline.
`default_nettype none

module adler32_checksum (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // Low to high: data_byte_0, data_byte_1, data_byte_2, data_byte_3, byte_count, seed.
    input  wire logic [adl_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    input  wire logic                           s_axis_tlast,
    // Fields: first.
    input  wire logic                           s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // Low to high: checksum.
    output logic      [adl_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
    import adl_pkg::*;

    logic                              r_v1;
    logic                              r_v2;
    t_ctrl                             r_ctrl1;
    t_ctrl                             n_ctrl1;
    logic [CNT_IN_W-1:0]               cnt_in;
    logic [LANES-1:0][CNT_W-1:0]       weight;
    logic [LANES-1:0][BYTE_W-1:0]      lane_byte;
    logic [LANES-1:0][WBYTE_W-1:0]     lane_wbyte;
    logic [SUM_W-1:0]                  sum_s;
    logic [SUM_W-1:0]                  sum_w;
    t_ctrl                             ctrl2;
    logic                              out_free;
    logic                              adv2;
    logic                              en1;
    logic                              en2;

    always_comb begin
        cnt_in = s_axis_tdata[SEED_LSB-1:CNT_LSB];
        if (32'(cnt_in) > LANES) begin
            n_ctrl1.count = CNT_W'(LANES);
        end else begin
            n_ctrl1.count = CNT_W'(cnt_in);
        end
        n_ctrl1.first  = s_axis_tuser;
        n_ctrl1.seed_a = fold17({1'b0, s_axis_tdata[SEED_LSB +: SUM_W]});
        n_ctrl1.seed_b = fold17({1'b0, s_axis_tdata[SEED_LSB + SUM_W +: SUM_W]});
        n_ctrl1.last   = s_axis_tlast;
        for (int i = 0; i < LANES; i++) begin
            if (32'(n_ctrl1.count) > i) begin
                weight[i] = CNT_W'(32'(n_ctrl1.count) - i);
            end else begin
                weight[i] = '0;
            end
        end
    end

    assign adv2          = r_v2 && (!ctrl2.last || out_free);
    assign en2           = !r_v2 || adv2;
    assign en1           = !r_v1 || en2;
    assign s_axis_tready = en1;

    genvar g;
    generate
        for (g = 0; g < LANES; g++) begin : g_lane
            adl_lane u_lane (
                .i_clk    (i_clk),
                .i_en     (en1),
                .i_byte   (s_axis_tdata[g*BYTE_W +: BYTE_W]),
                .i_weight (weight[g]),
                .o_byte   (lane_byte[g]),
                .o_wbyte  (lane_wbyte[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= s_axis_tvalid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_ctrl1 <= n_ctrl1;
        end
    end

    adl_merge u_merge (
        .i_clk   (i_clk),
        .i_en    (en2),
        .i_byte  (lane_byte),
        .i_wbyte (lane_wbyte),
        .i_ctrl  (r_ctrl1),
        .o_sum_s (sum_s),
        .o_sum_w (sum_w),
        .o_ctrl  (ctrl2)
    );

    adl_accum u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv2),
        .i_sum_s     (sum_s),
        .i_sum_w     (sum_w),
        .i_ctrl      (ctrl2),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_free  (out_free)
    );

endmodule

`default_nettype wire

// ----- rtl/adl_checker.sv -----
// Port-level checker for the Adler-32 checksum block and its bind to the top level.
`default_nettype none
`include "assert_macros.svh"

module adl_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           s_axis_tready,
    input  wire logic                           m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    input  wire logic [adl_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
    import adl_pkg::*;

    property p_out_hold;
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata);
    endproperty

    property p_sum_a_reduced;
        m_axis_tvalid |-> (17'(m_axis_tdata[SUM_W-1:0]) < ADLER_MOD);
    endproperty

    property p_sum_b_reduced;
        m_axis_tvalid |-> (17'(m_axis_tdata[M_TDATA_W-1:SUM_W]) < ADLER_MOD);
    endproperty

    property p_ready_when_free;
        (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready;
    endproperty

    `ADL_ASSERT(a_out_hold, i_clk, i_rst_n, p_out_hold, "stalled checksum changed")
    `ADL_ASSERT(a_sum_a_reduced, i_clk, i_rst_n, p_sum_a_reduced, "sum A not reduced")
    `ADL_ASSERT(a_sum_b_reduced, i_clk, i_rst_n, p_sum_b_reduced, "sum B not reduced")
    `ADL_ASSERT(a_ready_when_free, i_clk, i_rst_n, p_ready_when_free, "input stalled")
    `ADL_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !m_axis_tvalid, "valid after reset")

endmodule

bind adler32_checksum adl_checker u_adl_checker (.*);

`default_nettype wire
